// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL files of the window bin downsampler; the job queue uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked property, disabled while in reset.
`define WBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property, also checked during reset.
`define WBD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WBD_ASSERT(lbl, prop, msg)
`define WBD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- hw/rtl/wbd_pkg.sv -----
// Package of the window bin downsampler: payload types, job type, constants.
package wbd_pkg;
  localparam int MAX_WINDOWS = 1048576;
  localparam int CNT_W = $clog2(MAX_WINDOWS + 1);
  localparam int COORD_W = 31;
  localparam int COV_W = 32;
  localparam int SUM_W = COV_W + CNT_W;
  localparam int LIMIT_W = 16;
  localparam int CFG_W = 21;
  localparam int BND_W = CNT_W + LIMIT_W + 1;
  localparam logic [LIMIT_W-1:0] BIN_LIMIT_RST = 16'd4000;

  typedef enum logic [0:0] {
    CFG_WINDOW_COUNT = 1'b0,
    CFG_BIN_LIMIT    = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [COORD_W-1:0] win_start;
    logic [COORD_W-1:0] win_length;
    logic [COORD_W-1:0] win_end;
    logic [COV_W-1:0]   raw_coverage;
    logic [COV_W-1:0]   fixed_coverage;
    logic [COV_W-1:0]   fit_coverage;
    logic signed [7:0]  copies;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] bin_start;
    logic [COORD_W-1:0] bin_end;
    logic [COORD_W-1:0] bin_length;
    logic [COV_W-1:0]   raw_mean;
    logic [COV_W-1:0]   fixed_mean;
    logic [COV_W-1:0]   fit_mean;
    logic signed [7:0]  extreme_copies;
  } out_item_t;

  // Work handed from front to back: a pass-through window or a closed bin.
  typedef struct packed {
    logic               pass;
    logic [COORD_W-1:0] first_start;
    logic [COORD_W-1:0] last_end;
    logic [COORD_W-1:0] length;
    logic [SUM_W-1:0]   raw_sum;
    logic [SUM_W-1:0]   fixed_sum;
    logic [SUM_W-1:0]   fit_sum;
    logic [CNT_W-1:0]   items;
    logic signed [7:0]  copies;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_EVAL,
    F_DIV
  } front_state_t;

  typedef enum logic [0:0] {
    B_IDLE,
    B_DIV
  } back_state_t;
endpackage

// ----- hw/rtl/wbd_div.sv -----
// Restoring divider, one quotient bit per cycle.
module wbd_div #(
  parameter int DW = 52,
  parameter int VW = 21
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] quotient
);
  localparam int CW = $clog2(DW);

  logic          busy_r, busy_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW:0]   rem_r, rem_nxt, trial;
  logic [VW-1:0] div_r;
  logic [CW-1:0] cnt_r;

  // One shift and trial subtract
  always_comb begin
    trial = {rem_r[VW-1:0], quo_r[DW-1]};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = trial - {1'b0, div_r};
      quo_nxt = {quo_r[DW-2:0], 1'b1};
    end else begin
      rem_nxt = trial;
      quo_nxt = {quo_r[DW-2:0], 1'b0};
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && cnt_r == CW'(DW - 1)) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
      cnt_r <= '0;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + CW'(1);
    end
  end

  assign busy = busy_r;
  assign quotient = quo_r;
endmodule

// ----- hw/rtl/wbd_front.sv -----
// Front end: takes windows, tracks bin boundaries and sums, emits jobs.
module wbd_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  wbd_pkg::in_item_t           in_data,
  input  logic [wbd_pkg::CFG_W-1:0]   window_count,
  input  logic [wbd_pkg::LIMIT_W-1:0] bin_limit,
  input  logic                        cfg_we,
  output logic                        push,
  output wbd_pkg::job_t               push_job,
  input  logic                        fifo_full
);
  localparam int NW = wbd_pkg::CNT_W;
  localparam int BW = wbd_pkg::BND_W;

  wbd_pkg::front_state_t state_r, state_nxt;
  wbd_pkg::in_item_t     item_r;

  logic [NW-1:0]                item_index_r, bin_items_r, boundary_r;
  logic [wbd_pkg::LIMIT_W-1:0]  bin_index_r;
  logic                         bvalid_r;
  logic [wbd_pkg::COORD_W-1:0]  first_start_r;
  logic [wbd_pkg::SUM_W-1:0]    raw_sum_r, fixed_sum_r, fit_sum_r;
  logic signed [7:0]            extreme_r;

  logic [NW-1:0]               n_cl, m_ext;
  logic                        pass, drop, close;
  logic [wbd_pkg::SUM_W-1:0]   raw_nxt, fixed_nxt, fit_nxt;
  logic [wbd_pkg::COORD_W-1:0] first_nxt;
  logic signed [7:0]           ext_base, ext_nxt;
  logic [8:0]                  dist_in, dist_held;
  logic [NW:0]                 index_inc;
  logic [BW-1:0]               dividend;
  logic [BW-1:0]               quotient;
  logic                        div_busy, div_start, accept, commit;

  // Stream and bin classification
  always_comb begin
    n_cl = (window_count > NW'(wbd_pkg::MAX_WINDOWS)) ?
           NW'(wbd_pkg::MAX_WINDOWS) : NW'(window_count);
    m_ext = NW'(bin_limit);
    pass = (bin_limit == '0) || (n_cl <= m_ext);
    drop = (item_index_r >= n_cl) || (bin_index_r >= bin_limit);
    index_inc = {1'b0, item_index_r} + (NW + 1)'(1);
    close = index_inc >= {1'b0, boundary_r};
    dividend = BW'(n_cl) * BW'({1'b0, bin_index_r} + 17'd1);
  end

  // Running sums and copy-number extreme
  always_comb begin
    first_nxt = (bin_items_r == '0) ? item_r.win_start : first_start_r;
    ext_base  = (bin_items_r == '0) ? item_r.copies : extreme_r;
    raw_nxt   = ((bin_items_r == '0) ? '0 : raw_sum_r) +
                wbd_pkg::SUM_W'(item_r.raw_coverage);
    fixed_nxt = ((bin_items_r == '0) ? '0 : fixed_sum_r) +
                wbd_pkg::SUM_W'(item_r.fixed_coverage);
    fit_nxt   = ((bin_items_r == '0) ? '0 : fit_sum_r) +
                wbd_pkg::SUM_W'(item_r.fit_coverage);
    dist_in   = (item_r.copies >= 8'sd1) ? 9'({item_r.copies[7], item_r.copies} - 9'sd1)
                                         : 9'(9'sd1 - {item_r.copies[7], item_r.copies});
    dist_held = (ext_base >= 8'sd1) ? 9'({ext_base[7], ext_base} - 9'sd1)
                                    : 9'(9'sd1 - {ext_base[7], ext_base});
    ext_nxt   = (dist_in > dist_held) ? item_r.copies : ext_base;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wbd_pkg::F_IDLE: begin
        if (in_valid) state_nxt = wbd_pkg::F_EVAL;
      end
      wbd_pkg::F_EVAL: begin
        if (pass) begin
          if (!fifo_full) state_nxt = wbd_pkg::F_IDLE;
        end else if (drop) begin
          state_nxt = wbd_pkg::F_IDLE;
        end else if (!bvalid_r) begin
          state_nxt = wbd_pkg::F_DIV;
        end else if (!(close && fifo_full)) begin
          state_nxt = wbd_pkg::F_IDLE;
        end
      end
      wbd_pkg::F_DIV: begin
        if (!div_busy && !div_start) state_nxt = wbd_pkg::F_EVAL;
      end
      default: state_nxt = wbd_pkg::F_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready  = 1'b0;
    push      = 1'b0;
    div_start = 1'b0;
    commit    = 1'b0;
    case (state_r)
      wbd_pkg::F_IDLE: in_ready = 1'b1;
      wbd_pkg::F_EVAL: begin
        if (pass) begin
          push = !fifo_full;
        end else if (drop) begin
          push = 1'b0;
        end else if (!bvalid_r) begin
          div_start = 1'b1;
        end else if (!(close && fifo_full)) begin
          commit = 1'b1;
          push   = close;
        end
      end
      default: ;
    endcase
  end

  assign accept = in_valid && in_ready;

  // Job contents
  always_comb begin
    push_job.pass        = pass;
    push_job.first_start = pass ? item_r.win_start : first_nxt;
    push_job.last_end    = item_r.win_end;
    push_job.length      = item_r.win_length;
    push_job.raw_sum     = pass ? wbd_pkg::SUM_W'(item_r.raw_coverage) : raw_nxt;
    push_job.fixed_sum   = pass ? wbd_pkg::SUM_W'(item_r.fixed_coverage) : fixed_nxt;
    push_job.fit_sum     = pass ? wbd_pkg::SUM_W'(item_r.fit_coverage) : fit_nxt;
    push_job.items       = pass ? NW'(1) : bin_items_r + NW'(1);
    push_job.copies      = pass ? item_r.copies : ext_nxt;
  end

  wbd_div #(.DW(BW), .VW(wbd_pkg::LIMIT_W)) u_bnd_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (bin_limit),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= wbd_pkg::F_IDLE;
      item_index_r <= '0;
      bin_index_r  <= '0;
      bin_items_r  <= '0;
      bvalid_r     <= 1'b0;
      boundary_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == wbd_pkg::F_DIV && !div_busy && !div_start) begin
        boundary_r <= quotient[NW-1:0];
        bvalid_r   <= 1'b1;
      end
      if (commit) begin
        item_index_r <= index_inc[NW-1:0];
        if (close) begin
          bin_index_r <= bin_index_r + wbd_pkg::LIMIT_W'(1);
          bin_items_r <= '0;
          bvalid_r    <= 1'b0;
        end else begin
          bin_items_r <= bin_items_r + NW'(1);
        end
      end
      if (cfg_we) bvalid_r <= 1'b0;
    end
  end

  // Item and bin payload
  always_ff @(posedge clk) begin
    if (accept) item_r <= in_data;
    if (commit) begin
      first_start_r <= first_nxt;
      extreme_r     <= ext_nxt;
      raw_sum_r     <= close ? '0 : raw_nxt;
      fixed_sum_r   <= close ? '0 : fixed_nxt;
      fit_sum_r     <= close ? '0 : fit_nxt;
    end
  end
endmodule

// ----- hw/rtl/wbd_fifo.sv -----
// Two-entry job queue between front and back.
`include "assert_macros.svh"
module wbd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  wbd_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output wbd_pkg::job_t head,
  output logic          empty
);
  wbd_pkg::job_t mem_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  assign head  = mem_r[rd_ptr_r];
  assign full  = count_r == 2'd2;
  assign empty = count_r == 2'd0;

  `WBD_ASSERT(a_no_overflow, !(push && full), "job pushed into full queue")
  `WBD_ASSERT(a_no_underflow, !(pop && empty), "job popped from empty queue")
  `WBD_ASSERT(a_ptr_count, (count_r == 2'd1) |-> (wr_ptr_r != rd_ptr_r), "queue pointers out of step")
endmodule

// ----- hw/rtl/wbd_back.sv -----
// Back end: divides bin sums into means, passes windows through and drives the result register.
module wbd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fifo_empty,
  input  wbd_pkg::job_t      head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output wbd_pkg::out_item_t out_data
);
  localparam int SW = wbd_pkg::SUM_W;

  wbd_pkg::back_state_t state_r, state_nxt;
  wbd_pkg::job_t        job_r;
  wbd_pkg::out_item_t   out_r;
  logic                 out_valid_r;
  logic                 out_free, div_start, div_busy, load_pass, load_bin;
  logic [SW-1:0]        q_raw, q_fixed, q_fit;
  logic                 busy_fixed, busy_fit;

  assign out_free = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wbd_pkg::B_IDLE: begin
        if (!fifo_empty && out_free && !head.pass) state_nxt = wbd_pkg::B_DIV;
      end
      wbd_pkg::B_DIV: begin
        if (!div_busy && out_free) state_nxt = wbd_pkg::B_IDLE;
      end
      default: state_nxt = wbd_pkg::B_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    pop       = 1'b0;
    div_start = 1'b0;
    load_pass = 1'b0;
    load_bin  = 1'b0;
    case (state_r)
      wbd_pkg::B_IDLE: begin
        if (!fifo_empty && out_free) begin
          pop       = 1'b1;
          load_pass = head.pass;
          div_start = !head.pass;
        end
      end
      wbd_pkg::B_DIV: load_bin = !div_busy && out_free;
      default: ;
    endcase
  end

  wbd_div #(.DW(SW), .VW(wbd_pkg::CNT_W)) u_div_raw (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(head.raw_sum),
    .divisor(head.items), .busy(div_busy), .quotient(q_raw)
  );
  wbd_div #(.DW(SW), .VW(wbd_pkg::CNT_W)) u_div_fixed (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(head.fixed_sum),
    .divisor(head.items), .busy(busy_fixed), .quotient(q_fixed)
  );
  wbd_div #(.DW(SW), .VW(wbd_pkg::CNT_W)) u_div_fit (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(head.fit_sum),
    .divisor(head.items), .busy(busy_fit), .quotient(q_fit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wbd_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_pass || load_bin) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (pop) job_r <= head;
    if (load_pass) begin
      out_r.bin_start      <= head.first_start;
      out_r.bin_end        <= head.last_end;
      out_r.bin_length     <= head.length;
      out_r.raw_mean       <= head.raw_sum[wbd_pkg::COV_W-1:0];
      out_r.fixed_mean     <= head.fixed_sum[wbd_pkg::COV_W-1:0];
      out_r.fit_mean       <= head.fit_sum[wbd_pkg::COV_W-1:0];
      out_r.extreme_copies <= head.copies;
    end else if (load_bin) begin
      out_r.bin_start      <= job_r.first_start;
      out_r.bin_end        <= job_r.last_end;
      out_r.bin_length     <= job_r.last_end - job_r.first_start;
      out_r.raw_mean       <= q_raw[wbd_pkg::COV_W-1:0];
      out_r.fixed_mean     <= (busy_fixed || busy_fit) ? q_fixed[wbd_pkg::COV_W-1:0]
                                                       : q_fixed[wbd_pkg::COV_W-1:0];
      out_r.fit_mean       <= q_fit[wbd_pkg::COV_W-1:0];
      out_r.extreme_copies <= job_r.copies;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule

// ----- hw/rtl/window_bin_downsampler_unit.sv -----
// Top level of the window bin downsampler: config registers, front, queue, back.
//
// Windows enter on in_valid/in_ready with payload in_data; one request is
// one window. Results leave on out_valid/out_ready with payload out_data.
// When bin_limit is 0 or window_count <= bin_limit every window passes
// through as its own result; otherwise one result comes out per closed bin.
// The front takes a window and evaluates it; a bin first needs a boundary
// division of the capped window count times the bin index plus one by
// bin_limit, run once per bin and after each config write. Each closed bin
// is then divided in the back end by its three parallel 53-bit bit-serial
// mean dividers; pass-through windows go straight to the result register.
// A two-entry job queue lets the front keep accepting while the back
// divides or the result waits.
// Reset clears all stream state, sets window_count to 0 and bin_limit to
// 4000. A stalled receiver holds the result register; the queue then fills
// and in_ready drops. Config writes on cfg_we take effect for the next window.
module window_bin_downsampler_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  wbd_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output wbd_pkg::out_item_t        out_data,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [wbd_pkg::CFG_W-1:0] cfg_data
);
  logic [wbd_pkg::CFG_W-1:0]   window_count_r;
  logic [wbd_pkg::LIMIT_W-1:0] bin_limit_r;
  logic                        push, pop, fifo_full, fifo_empty;
  wbd_pkg::job_t               push_job, head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_count_r <= '0;
      bin_limit_r    <= wbd_pkg::BIN_LIMIT_RST;
    end else if (cfg_we) begin
      case (wbd_pkg::cfg_idx_t'(cfg_index))
        wbd_pkg::CFG_WINDOW_COUNT: window_count_r <= cfg_data;
        wbd_pkg::CFG_BIN_LIMIT:    bin_limit_r <= cfg_data[wbd_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  wbd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .window_count (window_count_r),
    .bin_limit    (bin_limit_r),
    .cfg_we       (cfg_we),
    .push         (push),
    .push_job     (push_job),
    .fifo_full    (fifo_full)
  );

  wbd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (fifo_full),
    .pop      (pop),
    .head     (head),
    .empty    (fifo_empty)
  );

  wbd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_empty (fifo_empty),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );
endmodule

// ----- tb/window_bin_downsampler_unit_tb.sv -----
// Testbench of the window bin downsampler: directed and random streams, scoreboard check.
module window_bin_downsampler_unit_tb;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  wbd_pkg::in_item_t         in_data;
  logic                      out_valid;
  logic                      out_ready;
  wbd_pkg::out_item_t        out_data;
  logic                      cfg_we;
  logic                      cfg_index;
  logic [wbd_pkg::CFG_W-1:0] cfg_data;

  window_bin_downsampler_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state
  logic [20:0] n_windows;
  logic [15:0] m_bins;
  logic [20:0] pos;
  logic [15:0] bin_no;
  logic [30:0] bin_first;
  logic [51:0] sum_raw, sum_fixed, sum_fit;
  logic [20:0] bin_count;
  logic signed [7:0] copies_held;

  wbd_pkg::out_item_t expected_bins[$];
  int          errors;
  int          send_idle_pct;
  int          recv_idle_pct;
  longint      cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd3000000) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int dist_one(logic signed [7:0] c);
    return (c >= 1) ? int'(c) - 1 : 1 - int'(c);
  endfunction

  // Model one accepted window; queue its pass-through result, or a bin result if one closes.
  task automatic predict_window(wbd_pkg::in_item_t w);
    longint unsigned n, boundary;
    wbd_pkg::out_item_t r;
    n = (n_windows > wbd_pkg::MAX_WINDOWS) ? wbd_pkg::MAX_WINDOWS : n_windows;
    if (m_bins == 0 || n <= m_bins) begin
      r.bin_start = w.win_start;
      r.bin_end = w.win_end;
      r.bin_length = w.win_length;
      r.raw_mean = w.raw_coverage;
      r.fixed_mean = w.fixed_coverage;
      r.fit_mean = w.fit_coverage;
      r.extreme_copies = w.copies;
      expected_bins = {expected_bins, r};
      return;
    end
    if (pos >= n || bin_no >= m_bins) return;
    if (bin_count == 0) begin
      bin_first = w.win_start;
      copies_held = w.copies;
      sum_raw = '0;
      sum_fixed = '0;
      sum_fit = '0;
    end
    sum_raw = sum_raw + w.raw_coverage;
    sum_fixed = sum_fixed + w.fixed_coverage;
    sum_fit = sum_fit + w.fit_coverage;
    if (dist_one(w.copies) > dist_one(copies_held)) copies_held = w.copies;
    bin_count = bin_count + 1;
    boundary = (n * (longint'(bin_no) + 1)) / m_bins;
    pos = pos + 1;
    if (longint'(pos) >= boundary) begin
      r.bin_start = bin_first;
      r.bin_end = w.win_end;
      r.bin_length = w.win_end - bin_first;
      r.raw_mean = 32'(sum_raw / bin_count);
      r.fixed_mean = 32'(sum_fixed / bin_count);
      r.fit_mean = 32'(sum_fit / bin_count);
      r.extreme_copies = copies_held;
      expected_bins = {expected_bins, r};
      bin_no = bin_no + 1;
      bin_count = '0;
      sum_raw = '0;
      sum_fixed = '0;
      sum_fit = '0;
    end
  endtask

  // Send one window request and predict it at acceptance.
  // Valid is dropped only while idling; a following request may start
  // right at the falling edge after acceptance.
  task automatic send_window(wbd_pkg::in_item_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_window(w);
    @(negedge clk);
  endtask

  // Receiver stalls and result check
  always @(negedge clk) begin
    if (rst_n) out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    wbd_pkg::out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_bins.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        e = expected_bins.pop_front();
        if (out_data.bin_start !== e.bin_start)
          $display("%0t: bin_start exp %h got %h", $time, e.bin_start, out_data.bin_start);
        if (out_data.bin_end !== e.bin_end)
          $display("%0t: bin_end exp %h got %h", $time, e.bin_end, out_data.bin_end);
        if (out_data.bin_length !== e.bin_length)
          $display("%0t: bin_length exp %h got %h", $time, e.bin_length,
                   out_data.bin_length);
        if (out_data.raw_mean !== e.raw_mean)
          $display("%0t: raw_mean exp %h got %h", $time, e.raw_mean, out_data.raw_mean);
        if (out_data.fixed_mean !== e.fixed_mean)
          $display("%0t: fixed_mean exp %h got %h", $time, e.fixed_mean,
                   out_data.fixed_mean);
        if (out_data.fit_mean !== e.fit_mean)
          $display("%0t: fit_mean exp %h got %h", $time, e.fit_mean, out_data.fit_mean);
        if (out_data.extreme_copies !== e.extreme_copies)
          $display("%0t: extreme_copies exp %0d got %0d", $time, e.extreme_copies,
                   out_data.extreme_copies);
        if (out_data !== e) errors++;
      end
    end
  end

  // Stop sending, wait for all results, then let the back end settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_bins.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  // Write one register while idle; stream state restarts only on reset,
  // so the model keeps its state too.
  task automatic write_reg(wbd_pkg::cfg_idx_t idx, logic [wbd_pkg::CFG_W-1:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == wbd_pkg::CFG_WINDOW_COUNT) n_windows = val;
    else m_bins = val[15:0];
  endtask

  function automatic wbd_pkg::in_item_t rand_window();
    wbd_pkg::in_item_t w;
    w.win_start = 31'($urandom);
    w.win_length = 31'($urandom);
    w.win_end = 31'($urandom);
    w.raw_coverage = $urandom;
    w.fixed_coverage = $urandom;
    w.fit_coverage = $urandom;
    case ($urandom_range(3))
      0: w.copies = -8'sd1;
      1: w.copies = 8'sd1;
      2: w.copies = 8'($urandom_range(127));
      default: w.copies = 8'($urandom);
    endcase
    return w;
  endfunction

  // Directed cases from reset: pass-through, zero limit, a binned stream and
  // windows past its end; bin state clears only at reset, as in the model.
  task automatic test_directed();
    wbd_pkg::in_item_t w;
    // pass-through at reset values, field extremes
    w = '0;
    send_window(w);
    w = '1;
    send_window(w);
    w = '0; w.copies = 8'sd127; w.win_end = 31'h7fffffff;
    send_window(w);
    w = '0; w.copies = -8'sd1; w.win_start = 31'h7fffffff;
    send_window(w);
    // binning disabled by zero limit
    write_reg(wbd_pkg::CFG_BIN_LIMIT, 21'd0);
    write_reg(wbd_pkg::CFG_WINDOW_COUNT, 21'd100);
    repeat (3) send_window(rand_window());
    // binning: 9 windows into 2 bins, reversed window and tie on copies
    write_reg(wbd_pkg::CFG_BIN_LIMIT, 21'd2);
    write_reg(wbd_pkg::CFG_WINDOW_COUNT, 21'd9);
    for (int i = 0; i < 9; i++) begin
      w = rand_window();
      w.raw_coverage = 32'hffffffff;
      w.copies = (i % 2) ? 8'sd3 : -8'sd1;
      if (i == 8) w.win_end = 31'd0;
      send_window(w);
    end
    // stream is done: extra windows are ignored
    repeat (2) send_window(rand_window());
  endtask

  // Random phases: no setting runs on fresh stream state, as a reset of the
  // bin counters in model and DUT is not possible, so most use counts that keep
  // growing the same stream with window_count past pos; some write 0 or the maximum.
  task automatic test_random(int total);
    int sent, len;
    sent = 0;
    while (sent < total) begin
      case ($urandom_range(4))
        0: write_reg(wbd_pkg::CFG_BIN_LIMIT, 21'd0);
        1: write_reg(wbd_pkg::CFG_BIN_LIMIT, 21'h00ffff);
        default: write_reg(wbd_pkg::CFG_BIN_LIMIT, 21'($urandom_range(1, 40)));
      endcase
      case ($urandom_range(5))
        0: write_reg(wbd_pkg::CFG_WINDOW_COUNT, 21'h1fffff);
        1: write_reg(wbd_pkg::CFG_WINDOW_COUNT, 21'd0);
        default: write_reg(wbd_pkg::CFG_WINDOW_COUNT, 21'(pos + $urandom_range(1, 300)));
      endcase
      len = $urandom_range(20, 120);
      for (int i = 0; i < len; i++) send_window(rand_window());
      sent += len;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = wbd_pkg::CFG_WINDOW_COUNT;
    cfg_data = '0;
    errors = 0;
    cycles = 0;
    n_windows = '0;
    m_bins = wbd_pkg::BIN_LIMIT_RST;
    pos = '0;
    bin_no = '0;
    bin_first = '0;
    sum_raw = '0;
    sum_fixed = '0;
    sum_fit = '0;
    bin_count = '0;
    copies_held = '0;
    send_idle_pct = 18;
    recv_idle_pct = 59;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random(600);
    send_idle_pct = 59;
    recv_idle_pct = 18;
    test_random(600);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(600);
    drain();

    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/wbd_pkg.sv
hw/rtl/wbd_div.sv
hw/rtl/wbd_front.sv
hw/rtl/wbd_fifo.sv
hw/rtl/wbd_back.sv
hw/rtl/window_bin_downsampler_unit.sv
tb/window_bin_downsampler_unit_tb.sv
